/* rtl/gnn_pkg.sv */
// ----------------------------------------------------------------------------
// gnn_pkg: shared constants and types for the nearest neighbor order block
// Widths of the distance path, the saturation cap and the cell operations.
// ----------------------------------------------------------------------------
`default_nettype none

package gnn_pkg;

   // Arrival index width of one item
   localparam int IDX_W = 6;

   // Greedy distance saturates here; every value below fits DIST_W bits
   localparam int DIST_W = 27;
   localparam logic [DIST_W-1:0] DIST_CAP = 27'd100000000;

   // Square, sum and root widths of the distance path
   localparam int SQ_W   = 2 * DIST_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int ROOT_W = (SUM_W + 1) / 2;

   // Operation of one list cell in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT,
      CELL_NEW,
      CELL_HEAD
   } cell_op_type;

endpackage

`default_nettype wire

/* rtl/gnn_cell.sv */
// ----------------------------------------------------------------------------
// gnn_cell: one entry of the working list
// Holds an arrival index and a start point; takes its neighbor, the new item
// or the list head as its operation selects.
// ----------------------------------------------------------------------------
`default_nettype none

module gnn_cell #(
   parameter int COORD_BITS = 25
) (
   input  wire                             clock,
   input  wire gnn_pkg::cell_op_type       op,
   input  wire signed [COORD_BITS-1:0]     left_x,
   input  wire signed [COORD_BITS-1:0]     left_y,
   input  wire        [gnn_pkg::IDX_W-1:0] left_idx,
   input  wire signed [COORD_BITS-1:0]     right_x,
   input  wire signed [COORD_BITS-1:0]     right_y,
   input  wire        [gnn_pkg::IDX_W-1:0] right_idx,
   input  wire signed [COORD_BITS-1:0]     new_x,
   input  wire signed [COORD_BITS-1:0]     new_y,
   input  wire        [gnn_pkg::IDX_W-1:0] new_idx,
   input  wire signed [COORD_BITS-1:0]     head_x,
   input  wire signed [COORD_BITS-1:0]     head_y,
   input  wire        [gnn_pkg::IDX_W-1:0] head_idx,
   output logic signed [COORD_BITS-1:0]    x_ff,
   output logic signed [COORD_BITS-1:0]    y_ff,
   output logic        [gnn_pkg::IDX_W-1:0] idx_ff
);

   // Load the selected entry
   always_ff @(posedge clock) begin
      unique case (op)
         gnn_pkg::CELL_FROM_LEFT: begin
            x_ff <= left_x;  y_ff <= left_y;  idx_ff <= left_idx;
         end
         gnn_pkg::CELL_FROM_RIGHT: begin
            x_ff <= right_x; y_ff <= right_y; idx_ff <= right_idx;
         end
         gnn_pkg::CELL_NEW: begin
            x_ff <= new_x;   y_ff <= new_y;   idx_ff <= new_idx;
         end
         gnn_pkg::CELL_HEAD: begin
            x_ff <= head_x;  y_ff <= head_y;  idx_ff <= head_idx;
         end
         default: begin
            x_ff <= x_ff;    y_ff <= y_ff;    idx_ff <= idx_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/gnn_dist.sv */
// ----------------------------------------------------------------------------
// gnn_dist: pipelined saturated integer distance
// Difference and magnitude, squares, sum, then one root bit per stage.
// Carries a tag alongside each valid sample.
// ----------------------------------------------------------------------------
`default_nettype none

module gnn_dist #(
   parameter int COORD_BITS = 25,
   parameter int TAG_W      = 56
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_valid,
   input  wire signed [COORD_BITS-1:0]       a_x,
   input  wire signed [COORD_BITS-1:0]       a_y,
   input  wire signed [COORD_BITS-1:0]       c_x,
   input  wire signed [COORD_BITS-1:0]       c_y,
   input  wire        [TAG_W-1:0]            in_tag,
   output logic                              out_valid,
   output logic       [gnn_pkg::DIST_W-1:0]  out_dist,
   output logic       [TAG_W-1:0]            out_tag,
   output logic                              busy
);

   localparam int DW = gnn_pkg::DIST_W;
   localparam int RW = gnn_pkg::ROOT_W;
   localparam int SW = gnn_pkg::SUM_W;

   logic signed [COORD_BITS:0] dx, dy;
   logic        [COORD_BITS:0] mx, my;
   logic        [63:0]         mx64, my64;

   logic          va_ff, vb_ff;
   logic          capa_ff, capb_ff;
   logic [DW-1:0] mxa_ff, mya_ff;
   logic [gnn_pkg::SQ_W-1:0] sqx_ff, sqy_ff;
   logic [TAG_W-1:0] taga_ff, tagb_ff;

   logic          vr_ff   [0:RW];
   logic          capr_ff [0:RW];
   logic [SW-1:0] rem_ff  [0:RW];
   logic [RW-1:0] root_ff [0:RW];
   logic [TAG_W-1:0] tagr_ff [0:RW];

   // Difference magnitudes
   always_comb begin
      dx   = {a_x[COORD_BITS-1], a_x} - {c_x[COORD_BITS-1], c_x};
      dy   = {a_y[COORD_BITS-1], a_y} - {c_y[COORD_BITS-1], c_y};
      mx   = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
      my   = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
      mx64 = 64'(mx);
      my64 = 64'(my);
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         vr_ff[0] <= 1'b0;
      end else begin
         va_ff    <= in_valid;
         vb_ff    <= va_ff;
         vr_ff[0] <= vb_ff;
      end
   end

   // Magnitude, square and sum stages
   always_ff @(posedge clock) begin
      capa_ff    <= (mx64 >= 64'(gnn_pkg::DIST_CAP)) || (my64 >= 64'(gnn_pkg::DIST_CAP));
      mxa_ff     <= mx64[DW-1:0];
      mya_ff     <= my64[DW-1:0];
      taga_ff    <= in_tag;
      sqx_ff     <= mxa_ff * mxa_ff;
      sqy_ff     <= mya_ff * mya_ff;
      capb_ff    <= capa_ff;
      tagb_ff    <= taga_ff;
      rem_ff[0]  <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      root_ff[0] <= '0;
      capr_ff[0] <= capb_ff;
      tagr_ff[0] <= tagb_ff;
   end

   // Root stages, most significant bit first
   for (genvar k = 0; k < RW; k++) begin : g_root
      localparam int J = RW - 1 - k;
      logic [63:0] trial;
      logic        ge;
      assign trial = (64'(root_ff[k]) << (J + 1)) + (64'd1 << (2 * J));
      assign ge    = 64'(rem_ff[k]) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vr_ff[k+1] <= 1'b0;
         end else begin
            vr_ff[k+1] <= vr_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= ge ? SW'(64'(rem_ff[k]) - trial) : rem_ff[k];
         root_ff[k+1] <= ge ? (root_ff[k] | (RW'(1) << J)) : root_ff[k];
         capr_ff[k+1] <= capr_ff[k];
         tagr_ff[k+1] <= tagr_ff[k];
      end
   end

   // Saturate the result and report activity
   always_comb begin
      out_valid = vr_ff[RW];
      out_tag   = tagr_ff[RW];
      if (capr_ff[RW] || (root_ff[RW] > RW'(gnn_pkg::DIST_CAP))) begin
         out_dist = gnn_pkg::DIST_CAP;
      end else begin
         out_dist = root_ff[RW][DW-1:0];
      end
      busy = va_ff | vb_ff;
      for (int s = 0; s <= RW; s++) begin
         busy = busy | vr_ff[s];
      end
   end

endmodule

`default_nettype wire

/* rtl/greedy_nearest_neighbor_order.sv */
// ----------------------------------------------------------------------------
// greedy_nearest_neighbor_order: greedy nearest neighbor tour over start points
// Loads points into a chain of list cells, then emits arrival indices in tour
// order, rotating the chain through a pipelined distance unit for each pick.
//
//   channel  direction  fields
//   req      in         start_x, start_y, last_item
//   rsp      out        item_index, last_out
//
// A loaded item goes through accept, square and insert, in that order.
// Each pick rotates the r remaining entries through the distance pipeline,
// then drains it.
// Reset clears the item count, front distance and control; cells need none.
// A result waiting on rsp holds the next pick until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_nearest_neighbor_order #(
   parameter int MAX_ITEMS  = 64,
   parameter int COORD_BITS = 25
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire signed [COORD_BITS-1:0]     req_start_x,
   input  wire signed [COORD_BITS-1:0]     req_start_y,
   input  wire                             req_last_item,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [gnn_pkg::IDX_W-1:0]       rsp_item_index,
   output logic                            rsp_last_out
);

   localparam int CNTW  = $clog2(MAX_ITEMS + 1);
   localparam int IW    = gnn_pkg::IDX_W;
   localparam int TAG_W = IW + 2 * COORD_BITS;
   localparam int DSQW  = 2 * COORD_BITS + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SQ    = 3'd1;
   localparam logic [2:0] S_INS   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_ROT   = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;

   logic [2:0]      state_ff;
   logic [CNTW-1:0] count_ff, len_ff, pass_len_ff, step_ff, drop_ord_ff;
   logic [CNTW-1:0] ord_cnt_ff, best_ord_ff;
   logic [DSQW-1:0] front_ff, dsq;
   logic signed [COORD_BITS-1:0] in_x_ff, in_y_ff, cur_x_ff, cur_y_ff;
   logic signed [COORD_BITS-1:0] best_x_ff, best_y_ff;
   logic [IW-1:0]   best_idx_ff;
   logic [gnn_pkg::DIST_W-1:0] best_d_ff;
   logic            in_last_ff;
   logic [COORD_BITS-1:0] ax, ay;
   logic [2*COORD_BITS-1:0] sqx_ff, sqy_ff;
   logic            front_ins, keep, feed;
   logic            rsp_valid_ff, rsp_last_ff;
   logic [IW-1:0]   rsp_idx_ff;

   logic signed [COORD_BITS-1:0] cx [0:MAX_ITEMS-1];
   logic signed [COORD_BITS-1:0] cy [0:MAX_ITEMS-1];
   logic [IW-1:0]   ci [0:MAX_ITEMS-1];
   gnn_pkg::cell_op_type cop [0:MAX_ITEMS-1];

   logic                       d_valid, d_busy;
   logic [gnn_pkg::DIST_W-1:0] d_dist;
   logic [TAG_W-1:0]           d_tag;

   // Squares of the captured point and insert decision
   always_comb begin
      ax        = in_x_ff[COORD_BITS-1] ? COORD_BITS'(-in_x_ff) : COORD_BITS'(in_x_ff);
      ay        = in_y_ff[COORD_BITS-1] ? COORD_BITS'(-in_y_ff) : COORD_BITS'(in_y_ff);
      dsq       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      front_ins = (count_ff != '0) && (dsq < front_ff);
      keep      = step_ff != drop_ord_ff;
      feed      = (state_ff == S_ROT) && keep;
      req_ready = state_ff == S_IDLE;
   end

   // Cell operations
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      always_comb begin
         if (state_ff == S_INS) begin
            if (front_ins) begin
               cop[i] = (i == 0) ? gnn_pkg::CELL_NEW : gnn_pkg::CELL_FROM_LEFT;
            end else begin
               cop[i] = (count_ff == CNTW'(i)) ? gnn_pkg::CELL_NEW : gnn_pkg::CELL_HOLD;
            end
         end else if (state_ff == S_ROT) begin
            cop[i] = (keep && (len_ff == CNTW'(i + 1))) ? gnn_pkg::CELL_HEAD
                                                       : gnn_pkg::CELL_FROM_RIGHT;
         end else begin
            cop[i] = gnn_pkg::CELL_HOLD;
         end
      end

      gnn_cell #(.COORD_BITS(COORD_BITS)) u_cell (
         .clock    (clock),
         .op       (cop[i]),
         .left_x   (cx[(i == 0) ? 0 : i - 1]),
         .left_y   (cy[(i == 0) ? 0 : i - 1]),
         .left_idx (ci[(i == 0) ? 0 : i - 1]),
         .right_x  (cx[(i == MAX_ITEMS - 1) ? i : i + 1]),
         .right_y  (cy[(i == MAX_ITEMS - 1) ? i : i + 1]),
         .right_idx(ci[(i == MAX_ITEMS - 1) ? i : i + 1]),
         .new_x    (in_x_ff),
         .new_y    (in_y_ff),
         .new_idx  (IW'(count_ff)),
         .head_x   (cx[0]),
         .head_y   (cy[0]),
         .head_idx (ci[0]),
         .x_ff     (cx[i]),
         .y_ff     (cy[i]),
         .idx_ff   (ci[i])
      );
   end

   gnn_dist #(.COORD_BITS(COORD_BITS), .TAG_W(TAG_W)) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (feed),
      .a_x      (cx[0]),
      .a_y      (cy[0]),
      .c_x      (cur_x_ff),
      .c_y      (cur_y_ff),
      .in_tag   ({ci[0], cx[0], cy[0]}),
      .out_valid(d_valid),
      .out_dist (d_dist),
      .out_tag  (d_tag),
      .busy     (d_busy)
   );

   // Capture point and squares
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_x_ff    <= req_start_x;
         in_y_ff    <= req_start_y;
         in_last_ff <= req_last_item;
      end
      sqx_ff <= ax * ax;
      sqy_ff <= ay * ay;
   end

   // Keep the first strict minimum of the pass
   always_ff @(posedge clock) begin
      if (d_valid && ((ord_cnt_ff == '0) || (d_dist < best_d_ff))) begin
         best_d_ff   <= d_dist;
         best_ord_ff <= ord_cnt_ff;
         {best_idx_ff, best_x_ff, best_y_ff} <= d_tag;
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ord_cnt_ff   <= '0;
         len_ff       <= '0;
         pass_len_ff  <= '0;
         step_ff      <= '0;
         drop_ord_ff  <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (d_valid) begin
            ord_cnt_ff <= ord_cnt_ff + 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (count_ff < CNTW'(MAX_ITEMS)) begin
                     state_ff <= S_SQ;
                  end else if (req_last_item) begin
                     state_ff <= S_START;
                  end
               end
            end
            S_SQ: begin
               state_ff <= S_INS;
            end
            S_INS: begin
               if ((count_ff == '0) || front_ins) begin
                  front_ff <= dsq;
               end
               count_ff <= count_ff + 1'b1;
               state_ff <= in_last_ff ? S_START : S_IDLE;
            end
            S_START: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_idx_ff   <= ci[0];
                  rsp_last_ff  <= count_ff == CNTW'(1);
                  cur_x_ff     <= cx[0];
                  cur_y_ff     <= cy[0];
                  if (count_ff == CNTW'(1)) begin
                     count_ff <= '0;
                     front_ff <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     len_ff      <= count_ff;
                     pass_len_ff <= count_ff;
                     step_ff     <= '0;
                     drop_ord_ff <= '0;
                     ord_cnt_ff  <= '0;
                     state_ff    <= S_ROT;
                  end
               end
            end
            S_ROT: begin
               if (!keep) begin
                  len_ff <= len_ff - 1'b1;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == pass_len_ff - 1'b1) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!d_busy && !rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_idx_ff   <= best_idx_ff;
                  rsp_last_ff  <= ord_cnt_ff == CNTW'(1);
                  cur_x_ff     <= best_x_ff;
                  cur_y_ff     <= best_y_ff;
                  if (ord_cnt_ff == CNTW'(1)) begin
                     count_ff <= '0;
                     front_ff <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     pass_len_ff <= len_ff;
                     step_ff     <= '0;
                     drop_ord_ff <= best_ord_ff;
                     ord_cnt_ff  <= '0;
                     state_ff    <= S_ROT;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_index = rsp_idx_ff;
   assign rsp_last_out   = rsp_last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_ITEMS))
      else $error("item count beyond capacity");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !d_busy)
      else $error("distance pipeline active while loading");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT) |-> (step_ff < pass_len_ff))
      else $error("rotation step past pass length");
   a_len_shrink: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT) |-> (len_ff <= pass_len_ff) && (len_ff + 1'b1 >= pass_len_ff))
      else $error("chain length lost more than one entry in a pass");

endmodule

`default_nettype wire
